[design/tvs_pkg.sv]
// ----------------------------------------------------------------------------
// Typed varint serializer package
// Shared types, opcodes, register indexes and helper functions.
// ----------------------------------------------------------------------------
package tvs_pkg;

    localparam int unsigned ID_W      = 32;
    localparam int unsigned VAL_W     = 64;
    localparam int unsigned CODE_W    = 3;
    localparam int unsigned PFX_W     = ID_W + CODE_W;
    localparam int unsigned GROUP_W   = 7;
    localparam int unsigned PFX_GRP_W = 3;
    localparam int unsigned PAY_CNT_W = 4;
    localparam int unsigned QDEPTH    = 2;
    localparam int unsigned QPTR_W    = $clog2(QDEPTH);
    localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [GROUP_W-1:0] GROUP_MASK = 7'h7F;
    localparam logic [7:0]         CONT_BIT   = 8'h80;

    // Opcodes, carried in the low bits of the input tuser.
    localparam logic [2:0] OP_AUTO  = 3'd0;
    localparam logic [2:0] OP_RAW32 = 3'd1;
    localparam logic [2:0] OP_RAW64 = 3'd2;
    localparam logic [2:0] OP_VAR   = 3'd3;
    localparam logic [2:0] OP_FIX16 = 3'd4;
    localparam logic [2:0] OP_FIX32 = 3'd5;
    localparam logic [2:0] OP_FIX48 = 3'd6;
    localparam logic [2:0] OP_FIX64 = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_VARSIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED16 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED32 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED48 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED64 = 3'd4;

    typedef struct packed {
        logic [CODE_W-1:0] varsize;
        logic [CODE_W-1:0] fixed16;
        logic [CODE_W-1:0] fixed32;
        logic [CODE_W-1:0] fixed48;
        logic [CODE_W-1:0] fixed64;
    } t_codes;

    // One classified request, as handed from the front end to the byte engine.
    typedef struct packed {
        logic                 ovf;
        logic                 has_pfx;
        logic [PFX_W-1:0]     pfx;
        logic [PFX_GRP_W-1:0] pfx_groups;
        logic                 pay_var;
        logic [VAL_W-1:0]     pay;
        logic [PAY_CNT_W-1:0] pay_cnt;
    } t_desc;

    // Number of 7-bit groups a varint of v needs (zero still takes one).
    function automatic logic [PAY_CNT_W-1:0] var_groups(input logic [VAL_W-1:0] v);
        logic [PAY_CNT_W-1:0] n;
        n = PAY_CNT_W'(1);
        for (int g = 1; g < (VAL_W + GROUP_W - 1) / GROUP_W; g++) begin
            if ((v >> (GROUP_W * g)) != '0) begin
                n = PAY_CNT_W'(g + 1);
            end
        end
        return n;
    endfunction

    function automatic logic [PFX_GRP_W-1:0] pfx_groups(input logic [PFX_W-1:0] p);
        logic [PFX_GRP_W-1:0] n;
        n = PFX_GRP_W'(1);
        for (int g = 1; g < (PFX_W + GROUP_W - 1) / GROUP_W; g++) begin
            if ((p >> (GROUP_W * g)) != '0) begin
                n = PFX_GRP_W'(g + 1);
            end
        end
        return n;
    endfunction

endpackage

[design/tvs_front.sv]
// ----------------------------------------------------------------------------
// Typed varint serializer front end
// Accepts requests, applies zigzag, picks the format and builds a descriptor.
// ----------------------------------------------------------------------------
module tvs_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tvs_pkg::t_codes       i_codes,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_opcode,
    input  logic [tvs_pkg::ID_W-1:0]  i_type_id,
    input  logic [tvs_pkg::VAL_W-1:0] i_value,
    input  logic                  i_zigzag,
    output logic                  o_valid,
    input  logic                  i_ready,
    output tvs_pkg::t_desc        o_desc
);

    logic                        r_valid;
    tvs_pkg::t_desc              r_desc;
    tvs_pkg::t_desc              n_desc;
    logic [tvs_pkg::VAL_W-1:0]   v;
    logic [tvs_pkg::CODE_W-1:0]  code;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_desc  = r_desc;

    always_comb begin
        v = i_zigzag ? ({i_value[tvs_pkg::VAL_W-2:0], 1'b0}
                        ^ {tvs_pkg::VAL_W{i_value[tvs_pkg::VAL_W-1]}})
                     : i_value;
        code               = i_codes.varsize;
        n_desc.ovf         = 1'b0;
        n_desc.has_pfx     = 1'b0;
        n_desc.pay_var     = 1'b0;
        n_desc.pay         = v;
        n_desc.pay_cnt     = tvs_pkg::PAY_CNT_W'(8);
        unique case (i_opcode)
            tvs_pkg::OP_AUTO: begin
                n_desc.has_pfx = 1'b1;
                // Format bands alternate between varint and fixed by magnitude.
                if (v[63:14] == '0) begin
                    n_desc.pay_var = 1'b1;
                end else if (v[63:16] == '0) begin
                    code           = i_codes.fixed16;
                    n_desc.pay_cnt = tvs_pkg::PAY_CNT_W'(2);
                end else if (v[63:28] == '0) begin
                    n_desc.pay_var = 1'b1;
                end else if (v[63:32] == '0) begin
                    code           = i_codes.fixed32;
                    n_desc.pay_cnt = tvs_pkg::PAY_CNT_W'(4);
                end else if (v[63:42] == '0) begin
                    n_desc.pay_var = 1'b1;
                end else if (v[63:48] == '0) begin
                    code           = i_codes.fixed48;
                    n_desc.pay_cnt = tvs_pkg::PAY_CNT_W'(6);
                end else if (v[63:56] == '0) begin
                    n_desc.pay_var = 1'b1;
                end else begin
                    code           = i_codes.fixed64;
                end
                if (n_desc.pay_var) begin
                    n_desc.pay_cnt = tvs_pkg::var_groups(v);
                end
            end
            tvs_pkg::OP_RAW32: begin
                n_desc.has_pfx = 1'b1;
                code           = i_codes.fixed32;
                n_desc.pay     = {32'd0, i_value[31:0]};
                n_desc.pay_cnt = tvs_pkg::PAY_CNT_W'(4);
            end
            tvs_pkg::OP_RAW64: begin
                n_desc.has_pfx = 1'b1;
                code           = i_codes.fixed64;
                n_desc.pay     = i_value;
            end
            tvs_pkg::OP_VAR: begin
                n_desc.pay_var = 1'b1;
                n_desc.pay_cnt = tvs_pkg::var_groups(v);
            end
            tvs_pkg::OP_FIX16: begin
                n_desc.pay     = {48'd0, v[15:0]};
                n_desc.pay_cnt = tvs_pkg::PAY_CNT_W'(2);
            end
            tvs_pkg::OP_FIX32: begin
                n_desc.pay     = {32'd0, v[31:0]};
                n_desc.pay_cnt = tvs_pkg::PAY_CNT_W'(4);
            end
            tvs_pkg::OP_FIX48: begin
                n_desc.ovf     = (v[63:48] != '0);
                n_desc.pay_cnt = tvs_pkg::PAY_CNT_W'(6);
            end
            tvs_pkg::OP_FIX64: begin
                n_desc.pay_cnt = tvs_pkg::PAY_CNT_W'(8);
            end
            default: begin
                n_desc.pay_cnt = tvs_pkg::PAY_CNT_W'(8);
            end
        endcase
        n_desc.pfx        = {i_type_id, code};
        n_desc.pfx_groups = tvs_pkg::pfx_groups(n_desc.pfx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_desc <= n_desc;
        end
    end

endmodule

[design/tvs_queue.sv]
// ----------------------------------------------------------------------------
// Typed varint serializer descriptor queue
// Short first-in first-out buffer between the front end and the byte engine.
// ----------------------------------------------------------------------------
module tvs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  tvs_pkg::t_desc i_wr_desc,
    output logic           o_rd_valid,
    input  logic           i_rd_pop,
    output tvs_pkg::t_desc o_rd_desc
);

    tvs_pkg::t_desc                r_mem [tvs_pkg::QDEPTH];
    logic [tvs_pkg::QPTR_W-1:0]    r_wr;
    logic [tvs_pkg::QPTR_W-1:0]    r_rd;
    logic [tvs_pkg::QCNT_W-1:0]    r_cnt;
    logic                          push;
    logic                          pop;

    assign o_wr_ready = (r_cnt != tvs_pkg::QCNT_W'(tvs_pkg::QDEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_desc  = r_mem[r_rd];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = i_rd_pop && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == tvs_pkg::QPTR_W'(tvs_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == tvs_pkg::QPTR_W'(tvs_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_wr_desc;
        end
    end

endmodule

[design/tvs_back.sv]
// ----------------------------------------------------------------------------
// Typed varint serializer byte engine
// Walks the head descriptor and sends one registered byte per cycle while ready.
// ----------------------------------------------------------------------------
module tvs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_desc_valid,
    input  tvs_pkg::t_desc i_desc,
    output logic           o_desc_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_byte,
    output logic           o_last,
    output logic           o_ovf
);

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'b01,
        PH_PAYLOAD = 2'b10
    } t_phase;

    logic                          r_valid;
    logic [7:0]                    r_byte;
    logic                          r_last;
    logic                          r_ovf;
    logic                          r_started;
    t_phase                        r_phase;
    logic [tvs_pkg::PAY_CNT_W-1:0] r_cnt;

    t_phase                        cur_phase;
    logic [tvs_pkg::PAY_CNT_W-1:0] cur_cnt;
    logic [tvs_pkg::PAY_CNT_W-1:0] idx;
    logic                          can_load;
    logic                          emit;
    logic                          item_last;
    logic [7:0]                    n_byte;
    logic [tvs_pkg::GROUP_W-1:0]   grp;
    logic [7:0]                    fix_byte;
    logic [69:0]                   pay_pad;

    assign o_valid  = r_valid;
    assign o_byte   = r_byte;
    assign o_last   = r_last;
    assign o_ovf    = r_ovf;
    assign can_load = !r_valid || i_ready;
    assign emit     = can_load && i_desc_valid;

    always_comb begin
        // A fresh descriptor starts straight from its own counts, not the registered ones.
        if (r_started) begin
            cur_phase = r_phase;
            cur_cnt   = r_cnt;
        end else if (i_desc.has_pfx) begin
            cur_phase = PH_PREFIX;
            cur_cnt   = tvs_pkg::PAY_CNT_W'(i_desc.pfx_groups);
        end else begin
            cur_phase = PH_PAYLOAD;
            cur_cnt   = i_desc.pay_cnt;
        end
        idx     = cur_cnt - 1'b1;
        pay_pad = {6'd0, i_desc.pay};

        grp = '0;
        if (cur_phase == PH_PREFIX) begin
            for (int g = 0; g < 5; g++) begin
                if (idx == tvs_pkg::PAY_CNT_W'(g)) begin
                    grp = i_desc.pfx[tvs_pkg::GROUP_W*g +: tvs_pkg::GROUP_W];
                end
            end
        end else begin
            for (int g = 0; g < 10; g++) begin
                if (idx == tvs_pkg::PAY_CNT_W'(g)) begin
                    grp = pay_pad[tvs_pkg::GROUP_W*g +: tvs_pkg::GROUP_W];
                end
            end
        end

        fix_byte = '0;
        for (int b = 0; b < 8; b++) begin
            if (idx == tvs_pkg::PAY_CNT_W'(b)) begin
                fix_byte = i_desc.pay[8*b +: 8];
            end
        end

        item_last = i_desc.ovf || (cur_phase == PH_PAYLOAD && cur_cnt == tvs_pkg::PAY_CNT_W'(1));

        if (i_desc.ovf) begin
            n_byte = 8'd0;
        end else if (cur_phase == PH_PREFIX || i_desc.pay_var) begin
            // Every group but the final one of a varint carries the continuation bit.
            n_byte = {1'b0, grp & tvs_pkg::GROUP_MASK}
                     | ((cur_cnt != tvs_pkg::PAY_CNT_W'(1)) ? tvs_pkg::CONT_BIT : 8'd0);
        end else begin
            n_byte = fix_byte;
        end
    end

    assign o_desc_pop = emit && item_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_started <= 1'b0;
            r_phase   <= PH_PREFIX;
            r_cnt     <= '0;
        end else begin
            if (can_load) begin
                r_valid <= i_desc_valid;
            end
            if (emit) begin
                if (item_last) begin
                    r_started <= 1'b0;
                end else if (cur_phase == PH_PREFIX && cur_cnt == tvs_pkg::PAY_CNT_W'(1)) begin
                    r_started <= 1'b1;
                    r_phase   <= PH_PAYLOAD;
                    r_cnt     <= i_desc.pay_cnt;
                end else begin
                    r_started <= 1'b1;
                    r_phase   <= cur_phase;
                    r_cnt     <= cur_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= n_byte;
            r_last <= item_last;
            r_ovf  <= i_desc.ovf;
        end
    end

endmodule

[design/typed_varint_serializer.sv]
// ----------------------------------------------------------------------------
// Typed varint serializer
// Turns one value with an opcode and type id into its serialized byte stream.
// ----------------------------------------------------------------------------
// Each request produces between one and thirteen output bytes, one per cycle
// while the output is ready, with tlast on the final byte; the byte-wide
// output register sets the rate. The front end classifies a request in one
// registered step and a two-entry queue lets it take new requests while
// earlier ones are still being sent, so back-to-back requests follow one
// another on the output without gaps. A fixed 48-bit write of a value wider
// than 48 bits yields a single zero byte with tuser set. The user must write format
// codes through the configuration port only while idle; the block does not enforce it.
module typed_varint_serializer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [tvs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tvs_pkg::CODE_W-1:0]       i_cfg_wdata,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [95:0]                      i_s_tdata,  // type_id[31:0], value_in[95:32]
    input  logic [3:0]                       i_s_tuser,  // opcode[2:0], zigzag[3]
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [7:0]                       o_m_tdata,  // out_byte[7:0]
    output logic                             o_m_tlast,
    output logic [0:0]                       o_m_tuser   // overflow[0]
);

    tvs_pkg::t_codes r_codes;
    logic            f_valid;
    logic            f_ready;
    tvs_pkg::t_desc  f_desc;
    logic            q_valid;
    logic            q_pop;
    tvs_pkg::t_desc  q_desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.varsize <= 3'd0;
            r_codes.fixed16 <= 3'd1;
            r_codes.fixed32 <= 3'd2;
            r_codes.fixed48 <= 3'd3;
            r_codes.fixed64 <= 3'd4;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                tvs_pkg::REG_VARSIZE: r_codes.varsize <= i_cfg_wdata;
                tvs_pkg::REG_FIXED16: r_codes.fixed16 <= i_cfg_wdata;
                tvs_pkg::REG_FIXED32: r_codes.fixed32 <= i_cfg_wdata;
                tvs_pkg::REG_FIXED48: r_codes.fixed48 <= i_cfg_wdata;
                tvs_pkg::REG_FIXED64: r_codes.fixed64 <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    tvs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_codes   (r_codes),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_opcode  (i_s_tuser[2:0]),
        .i_type_id (i_s_tdata[31:0]),
        .i_value   (i_s_tdata[95:32]),
        .i_zigzag  (i_s_tuser[3]),
        .o_valid   (f_valid),
        .i_ready   (f_ready),
        .o_desc    (f_desc)
    );

    tvs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_desc  (f_desc),
        .o_rd_valid (q_valid),
        .i_rd_pop   (q_pop),
        .o_rd_desc  (q_desc)
    );

    tvs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (q_valid),
        .i_desc       (q_desc),
        .o_desc_pop   (q_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_byte       (o_m_tdata),
        .o_last       (o_m_tlast),
        .o_ovf        (o_m_tuser[0])
    );

endmodule
